// ----- hw/rtl/lsf_pkg.sv -----
// shared types, constants and character helpers for the literal substring finder
package lsf_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int PAT_CHARS         = 16;
  localparam int CFG_DATA_W        = 64;
  localparam int RESULT_POS_W      = 16;
  localparam logic [7:0] UNDERSCORE_CODE = 8'h5F;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW     = 3'd0,
    REG_PATTERN_HIGH    = 3'd1,
    REG_PATTERN_LENGTH  = 3'd2,
    REG_IGNORE_CASE     = 3'd3,
    REG_WHOLE_WORD      = 3'd4,
    REG_SEARCH_BACKWARD = 3'd5
  } lsf_reg_t;

  typedef struct packed {
    logic [PAT_CHARS-1:0][7:0] pattern;
    logic [4:0]                pattern_length;
    logic                      ignore_case;
    logic                      whole_word;
    logic                      search_backward;
  } lsf_cfg_t;

  typedef struct packed {
    logic                    found;
    logic [RESULT_POS_W-1:0] match_position;
  } lsf_result_t;

  function automatic logic is_word(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (c == UNDERSCORE_CODE);
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
    if (ic && (c inside {[8'h61:8'h7A]})) begin
      return c - 8'd32;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/lsf_cfg.sv -----
// configuration register file of the literal substring finder
module lsf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output lsf_pkg::lsf_cfg_t                cfg
);
  import lsf_pkg::*;

  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [4:0]            len_r;
  logic                  ic_r, ww_r, bwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_r      <= 5'd1;
      ic_r       <= 1'b0;
      ww_r       <= 1'b0;
      bwd_r      <= 1'b0;
    end else if (cfg_we) begin
      case (lsf_reg_t'(cfg_index))
        REG_PATTERN_LOW:     pat_low_r  <= cfg_wdata;
        REG_PATTERN_HIGH:    pat_high_r <= cfg_wdata;
        REG_PATTERN_LENGTH:  len_r      <= cfg_wdata[4:0];
        REG_IGNORE_CASE:     ic_r       <= cfg_wdata[0];
        REG_WHOLE_WORD:      ww_r       <= cfg_wdata[0];
        REG_SEARCH_BACKWARD: bwd_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern         = {pat_high_r, pat_low_r};
  assign cfg.pattern_length  = len_r;
  assign cfg.ignore_case     = ic_r;
  assign cfg.whole_word      = ww_r;
  assign cfg.search_backward = bwd_r;

endmodule

// ----- hw/rtl/lsf_core.sv -----
// per-line search state: character window, compare, bound check and match selection
module lsf_core #(
  parameter int MAX_PATTERN   = lsf_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = lsf_pkg::POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            char_code,
  input  logic                  line_end,
  input  logic                  bound_valid,
  input  logic [15:0]           bound_position,
  input  lsf_pkg::lsf_cfg_t     cfg,
  output lsf_pkg::lsf_result_t  result
);
  import lsf_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 2);
  localparam int WIN_AW = $clog2(MAX_PATTERN + 1);
  localparam int PB     = POSITION_BITS;
  localparam int SUM_W  = POSITION_BITS + LEN_W;
  localparam logic [LEN_W-1:0] FILL_MAX = LEN_W'(MAX_PATTERN + 1);

  logic [7:0]       win_r   [MAX_PATTERN];
  logic [7:0]       win_nxt [MAX_PATTERN+1];
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [PB-1:0]    index_r;
  logic             at_start_r;
  logic             bound_ok_r;
  logic [PB-1:0]    bound_r;
  logic             pend_ok_r, pend_ok_nxt;
  logic [PB-1:0]    pend_pos_r, pend_pos_nxt;
  logic             best_ok_r, best_ok_nxt;
  logic [PB-1:0]    best_pos_r, best_pos_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] tap_idx [MAX_PATTERN];
  logic             first_word, last_word;
  logic             bound_ok_e;
  logic [PB-1:0]    bound_e;
  logic [31:0]      bound_ext, best_ext;
  logic             hit, left_ok, in_bound, qual, right_ok;
  logic [PB-1:0]    start_pos;

  // clamp the configured length into 1..MAX_PATTERN
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.pattern_length > 5'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  assign first_word = is_word(cfg.pattern[0]);
  assign last_word  = is_word(cfg.pattern[4'(eff_len - LEN_W'(1))]);

  always_comb begin
    win_nxt[0] = char_code;
    for (int i = 1; i <= MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tap_idx[k] = eff_len - LEN_W'(k + 1);
    end
  end

  assign fill_nxt   = (fill_r == FILL_MAX) ? fill_r : fill_r + LEN_W'(1);
  assign bound_ext  = 32'(bound_position);
  assign bound_ok_e = at_start_r ? bound_valid : bound_ok_r;
  assign bound_e    = at_start_r ? bound_ext[PB-1:0] : bound_r;
  assign start_pos  = index_r - PB'(eff_len - LEN_W'(1));

  always_comb begin
    hit = (fill_nxt >= eff_len);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((LEN_W'(k) < eff_len) &&
          (fold_char(win_nxt[tap_idx[k][WIN_AW-1:0]], cfg.ignore_case) !=
           fold_char(cfg.pattern[k], cfg.ignore_case))) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    left_ok = !cfg.whole_word || !first_word || (fill_nxt == eff_len) ||
              !is_word(win_nxt[eff_len[WIN_AW-1:0]]);
    if (!bound_ok_e) begin
      in_bound = 1'b1;
    end else if (cfg.search_backward) begin
      in_bound = (SUM_W'(start_pos) + SUM_W'(eff_len) + SUM_W'(1)) <= SUM_W'(bound_e);
    end else begin
      in_bound = {1'b0, start_pos} >= ({1'b0, bound_e} + (PB+1)'(1));
    end
    qual     = hit && left_ok && in_bound;
    right_ok = !cfg.whole_word || !last_word || line_end;
  end

  // a held match is taken first, then this character's match
  always_comb begin
    best_ok_nxt  = best_ok_r;
    best_pos_nxt = best_pos_r;
    if (pend_ok_r && !is_word(char_code) && (cfg.search_backward || !best_ok_nxt)) begin
      best_ok_nxt  = 1'b1;
      best_pos_nxt = pend_pos_r;
    end
    if (qual && right_ok && (cfg.search_backward || !best_ok_nxt)) begin
      best_ok_nxt  = 1'b1;
      best_pos_nxt = start_pos;
    end
    pend_ok_nxt  = qual && !right_ok;
    pend_pos_nxt = start_pos;
  end

  assign best_ext              = 32'(best_pos_nxt);
  assign result.found          = best_ok_nxt;
  assign result.match_position = best_ok_nxt ? best_ext[RESULT_POS_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= win_nxt[i];
      end
      bound_r    <= bound_e;
      pend_pos_r <= pend_pos_nxt;
      best_pos_r <= best_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      index_r    <= '0;
      at_start_r <= 1'b1;
      bound_ok_r <= 1'b0;
      pend_ok_r  <= 1'b0;
      best_ok_r  <= 1'b0;
    end else if (step) begin
      if (line_end) begin
        fill_r     <= '0;
        index_r    <= '0;
        at_start_r <= 1'b1;
        bound_ok_r <= 1'b0;
        pend_ok_r  <= 1'b0;
        best_ok_r  <= 1'b0;
      end else begin
        fill_r     <= fill_nxt;
        index_r    <= index_r + PB'(1);
        at_start_r <= 1'b0;
        bound_ok_r <= bound_ok_e;
        pend_ok_r  <= pend_ok_nxt;
        best_ok_r  <= best_ok_nxt;
      end
    end
  end

endmodule

// ----- hw/rtl/literal_substring_finder.sv -----
// top level of the literal substring finder: input register, search core, result register
//
// Streams one line of text, one character per item, and at the item flagged
// line_end returns one result: found and the start index of the first match
// (forward) or the last match (backward) of a pattern of 1 to MAX_PATTERN
// characters. An item is accepted on every cycle the result register is free
// or being taken, so the rate is one character per cycle; the full window
// compare is combinational between the input register and the search state.
// A result enters the output register as its line_end item leaves the input
// register and is held there while out_stall is high; a further line_end item then
// waits in the input register, and input stalls only in that case. Options
// (case folding, whole-word edges, search direction) and the pattern are
// written through the cfg port between lines. The optional bound is sampled
// with the first character of a line. Positions count modulo 2^POSITION_BITS.
module literal_substring_finder #(
  parameter int MAX_PATTERN   = lsf_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = lsf_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // character items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_line_end,
  input  logic                                in_bound_valid,
  input  logic [15:0]                         in_bound_position,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [lsf_pkg::RESULT_POS_W-1:0]    out_match_position
);
  import lsf_pkg::*;

  lsf_cfg_t    cfg;
  lsf_result_t core_res;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        s1_bv_r;
  logic [15:0] s1_bpos_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r;
  logic [RESULT_POS_W-1:0] out_pos_r;

  logic in_take, s1_adv, out_take, out_load;

  // a non-final character never waits; a final one waits for a free result slot
  assign out_take = out_valid_r && !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign out_load = s1_adv && s1_last_r;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_line_end;
      s1_bv_r   <= in_bound_valid;
      s1_bpos_r <= in_bound_position;
    end
    if (out_load) begin
      out_found_r <= core_res.found;
      out_pos_r   <= core_res.match_position;
    end
  end

  lsf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsf_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_adv),
    .char_code      (s1_char_r),
    .line_end       (s1_last_r),
    .bound_valid    (s1_bv_r),
    .bound_position (s1_bpos_r),
    .cfg            (cfg),
    .result         (core_res)
  );

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;

endmodule

// ----- hw/rtl/lsf_checker.sv -----
// port-level checks of the literal substring finder and their binding
module lsf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_line_end,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_found,
  input logic [lsf_pkg::RESULT_POS_W-1:0]  out_match_position
);
  import lsf_pkg::*;

  // held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
                               $stable(out_match_position))
    else $error("result changed while stalled");

  // no match reports position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_position == '0)
    else $error("nonzero position without a match");

  // input only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

  // a fresh result follows an accepted line end item
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_line_end, 2))
    else $error("result without a line end item");

endmodule

bind literal_substring_finder lsf_checker u_lsf_checker (.*);
